// ===== design/rhsa_pkg.sv =====
// Shared types, constants and helpers for the rotating-hint slot allocator.
// No dependencies; imported by every module of the block.
package rhsa_pkg;

  localparam int DEF_POOL_SLOTS   = 2048;
  localparam int DEF_INLINE_BYTES = 512;
  localparam logic [31:0] DEF_SIZE_LIMIT = 32'd65536;

  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;
  localparam int SLOT_W    = 16;
  localparam int SIZE_W    = 32;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_USE_PAGES = 3'd2,
    ST_POOL_FULL = 3'd3,
    ST_FREED     = 3'd4,
    ST_BAD_INDEX = 3'd5
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [SIZE_W-1:0]  req_bytes;
    logic [SLOT_W-1:0]  slot_index;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
  } res_t;

  typedef struct packed {
    logic              found;
    logic [BIT_W-1:0]  pos;
  } find_t;

  // lowest set bit of a busy-map word
  function automatic find_t lowest_set(input logic [WORD_BITS-1:0] v);
    find_t r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.pos   = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== design/rhsa_busy_mem.sv =====
// Busy-map storage: one 64-bit word per 64 slots, one write and one read port.
// Read data is registered. Uses rhsa_pkg.
module rhsa_busy_mem
  import rhsa_pkg::*;
#(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/rhsa_ctrl.sv =====
// Sequencer: clearing pass, request decode, word-by-word circular free search
// and read-modify-write of the busy map. Uses rhsa_pkg, drives rhsa_busy_mem.
module rhsa_ctrl
  import rhsa_pkg::*;
#(
  parameter int POOL_SLOTS   = DEF_POOL_SLOTS,
  parameter int INLINE_BYTES = DEF_INLINE_BYTES,
  parameter int NUM_WORDS    = (POOL_SLOTS + WORD_BITS - 1) / WORD_BITS,
  parameter int ADDR_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [SIZE_W-1:0]    size_limit,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_t                 req,
  output logic                 res_valid,
  input  logic                 res_ready,
  output res_t                 res,
  output logic                 wr_en,
  output logic [ADDR_W-1:0]    wr_addr,
  output logic [WORD_BITS-1:0] wr_data,
  output logic                 rd_en,
  output logic [ADDR_W-1:0]    rd_addr,
  input  logic [WORD_BITS-1:0] rd_data
);

  localparam int HINT_W    = ADDR_W + BIT_W;
  localparam int STEP_W    = $clog2(NUM_WORDS + 1);
  localparam int LAST_BITS = POOL_SLOTS - (NUM_WORDS - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FREE  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t               state, state_next;
  logic [ADDR_W-1:0]    clr_cnt, clr_cnt_next;
  logic [HINT_W-1:0]    hint, hint_next;
  logic [ADDR_W-1:0]    word, word_next;
  logic [BIT_W-1:0]     off, off_next;
  logic [STEP_W-1:0]    step, step_next;
  res_t                 res_q, res_next;

  logic [HINT_W:0]      hint_inc;
  logic [ADDR_W-1:0]    word_wrap;
  logic [WORD_BITS-1:0] lo_mask, step_mask, pool_mask, avail;
  find_t                hit;

  assign hint_inc  = {1'b0, hint} + (HINT_W+1)'(1);
  assign word_wrap = (word == ADDR_W'(NUM_WORDS - 1)) ? '0 : word + ADDR_W'(1);
  assign lo_mask   = {WORD_BITS{1'b1}} << off;
  assign pool_mask = (word == ADDR_W'(NUM_WORDS - 1)) ? LAST_MASK : {WORD_BITS{1'b1}};

  always_comb begin
    if (step == '0) begin
      step_mask = lo_mask;
    end else if (step == STEP_W'(NUM_WORDS)) begin
      step_mask = ~lo_mask;
    end else begin
      step_mask = {WORD_BITS{1'b1}};
    end
  end

  assign avail = ~rd_data & step_mask & pool_mask;
  assign hit   = lowest_set(avail);

  always_comb begin
    state_next   = state;
    clr_cnt_next = clr_cnt;
    hint_next    = hint;
    word_next    = word;
    off_next     = off;
    step_next    = step;
    res_next     = res_q;
    req_ready    = 1'b0;
    res_valid    = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = word;
    wr_data      = rd_data;
    rd_en        = 1'b0;
    rd_addr      = word;
    unique case (state)
      S_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_cnt;
        wr_data      = '0;
        clr_cnt_next = clr_cnt + ADDR_W'(1);
        if (clr_cnt == ADDR_W'(NUM_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          res_next = '{status: ST_FREED, slot: '0};
          if (req.op == OP_FREE) begin
            if ({1'b0, req.slot_index} < (SLOT_W+1)'(POOL_SLOTS)) begin
              word_next  = req.slot_index[HINT_W-1:BIT_W];
              off_next   = req.slot_index[BIT_W-1:0];
              rd_en      = 1'b1;
              rd_addr    = word_next;
              state_next = S_FREE;
            end else begin
              res_next.status = ST_BAD_INDEX;
              state_next      = S_DONE;
            end
          end else if (req.req_bytes > size_limit) begin
            res_next.status = ST_TOO_LARGE;
            state_next      = S_DONE;
          end else if (req.req_bytes > SIZE_W'(INLINE_BYTES)) begin
            res_next.status = ST_USE_PAGES;
            state_next      = S_DONE;
          end else begin
            word_next  = hint[HINT_W-1:BIT_W];
            off_next   = hint[BIT_W-1:0];
            step_next  = '0;
            hint_next  = (hint_inc == (HINT_W+1)'(POOL_SLOTS)) ? '0 : hint_inc[HINT_W-1:0];
            rd_en      = 1'b1;
            rd_addr    = word_next;
            state_next = S_SCAN;
          end
        end
      end
      S_FREE: begin
        wr_en      = 1'b1;
        wr_data    = rd_data & ~(WORD_BITS'(1) << off);
        state_next = S_DONE;
      end
      S_SCAN: begin
        if (hit.found) begin
          wr_en      = 1'b1;
          wr_data    = rd_data | (WORD_BITS'(1) << hit.pos);
          res_next   = '{status: ST_GRANTED, slot: SLOT_W'({word, hit.pos})};
          state_next = S_DONE;
        end else if (step == STEP_W'(NUM_WORDS)) begin
          res_next   = '{status: ST_POOL_FULL, slot: '0};
          state_next = S_DONE;
        end else begin
          step_next = step + STEP_W'(1);
          word_next = word_wrap;
          rd_en     = 1'b1;
          rd_addr   = word_wrap;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign res = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      hint    <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      hint    <= hint_next;
    end
  end

  always_ff @(posedge clk) begin
    word  <= word_next;
    off   <= off_next;
    step  <= step_next;
    res_q <= res_next;
  end

  a_hint_in_pool: assert property (@(posedge clk) disable iff (rst)
    {1'b0, hint} < (HINT_W+1)'(POOL_SLOTS))
    else $error("search hint left the pool");

  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    wr_en && rd_en |-> wr_addr != rd_addr)
    else $error("read and write of the same busy word in one cycle");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> step <= STEP_W'(NUM_WORDS))
    else $error("search ran past one full turn");

  a_grant_in_pool: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_GRANTED |-> {1'b0, res.slot} < (SLOT_W+1)'(POOL_SLOTS))
    else $error("granted slot outside the pool");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && !res_ready |=> state == S_DONE && $stable(res_q))
    else $error("pending result lost");

endmodule

// ===== design/rotating_hint_slot_allocator.sv =====
// Allocate: one busy-map word read per cycle, NUM_WORDS+1 reads at most (33 at
// 2048 slots). One request at a time; the next beat is taken only after the
// result has entered the output register. After rst the busy map is cleared
// one word per cycle, NUM_WORDS words (32 by default), before s_axis_tready
// rises. Stream ports, size_limit reg; uses rhsa_pkg.
module rotating_hint_slot_allocator
  import rhsa_pkg::*;
#(
  parameter int POOL_SLOTS   = DEF_POOL_SLOTS,
  parameter int INLINE_BYTES = DEF_INLINE_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,      // size_limit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // req_bytes[31:0], slot_index[47:32]
  input  logic [0:0]  s_axis_tuser,   // operation[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // granted_slot[15:0]
  output logic [2:0]  m_axis_tuser    // status[2:0]
);

  localparam int NUM_WORDS = (POOL_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  logic [SIZE_W-1:0]    size_limit;
  req_t                 req;
  res_t                 res, out_q;
  logic                 res_valid, res_ready;
  logic                 wr_en, rd_en;
  logic [ADDR_W-1:0]    wr_addr, rd_addr;
  logic [WORD_BITS-1:0] wr_data, rd_data;

  assign req = '{op: op_t'(s_axis_tuser[0]),
                 req_bytes: s_axis_tdata[31:0],
                 slot_index: s_axis_tdata[47:32]};

  always_ff @(posedge clk) begin
    if (rst) begin
      size_limit <= DEF_SIZE_LIMIT;
    end else if (cfg_we) begin
      size_limit <= cfg_wdata;
    end
  end

  rhsa_ctrl #(
    .POOL_SLOTS   (POOL_SLOTS),
    .INLINE_BYTES (INLINE_BYTES),
    .NUM_WORDS    (NUM_WORDS),
    .ADDR_W       (ADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .size_limit (size_limit),
    .req_valid  (s_axis_tvalid),
    .req_ready  (s_axis_tready),
    .req        (req),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  rhsa_busy_mem #(
    .DEPTH  (NUM_WORDS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tdata = out_q.slot;
  assign m_axis_tuser = out_q.status;

endmodule

// ===== sim/tb_rotating_hint_slot_allocator.sv =====
// Self-checking testbench for rotating_hint_slot_allocator: directed table, random
// beats over several size_limit settings, an allocation burst, then churn.
// Depends on rhsa_pkg and the allocator RTL only.
module tb_rotating_hint_slot_allocator;
  import rhsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POOL   = DEF_POOL_SLOTS;
  localparam int unsigned INLINE = DEF_INLINE_BYTES;

  typedef struct packed {
    logic        is_cfg;
    op_t         op;
    logic [31:0] value;
    logic [15:0] idx;
    logic        typed;
    status_t     st;
    logic [15:0] slot;
  } dir_row_t;

  localparam int DIR_N = 24;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{1'b0, OP_ALLOC, 32'd0,          16'hFFFF, 1'b1, ST_GRANTED,   16'd0},
    '{1'b0, OP_ALLOC, 32'd512,        16'd0,    1'b1, ST_GRANTED,   16'd1},
    '{1'b0, OP_ALLOC, 32'd513,        16'd0,    1'b1, ST_USE_PAGES, 16'd0},
    '{1'b0, OP_ALLOC, 32'd65536,      16'd0,    1'b1, ST_USE_PAGES, 16'd0},
    '{1'b0, OP_ALLOC, 32'd65537,      16'd0,    1'b1, ST_TOO_LARGE, 16'd0},
    '{1'b0, OP_ALLOC, 32'hFFFF_FFFF,  16'hFFFF, 1'b1, ST_TOO_LARGE, 16'd0},
    '{1'b0, OP_ALLOC, 32'd1,          16'd0,    1'b1, ST_GRANTED,   16'd2},
    '{1'b0, OP_FREE,  32'hFFFF_FFFF,  16'd0,    1'b1, ST_FREED,     16'd0},
    '{1'b0, OP_FREE,  32'd0,          16'd0,    1'b1, ST_FREED,     16'd0},
    '{1'b0, OP_FREE,  32'd0,          16'd2047, 1'b1, ST_FREED,     16'd0},
    '{1'b0, OP_FREE,  32'd0,          16'd2048, 1'b1, ST_BAD_INDEX, 16'd0},
    '{1'b0, OP_FREE,  32'd0,          16'hFFFF, 1'b1, ST_BAD_INDEX, 16'd0},
    '{1'b0, OP_ALLOC, 32'd300,        16'd5,    1'b0, ST_GRANTED,   16'd0},
    '{1'b1, OP_ALLOC, 32'd0,          16'd0,    1'b0, ST_GRANTED,   16'd0},
    '{1'b0, OP_ALLOC, 32'd0,          16'd0,    1'b0, ST_GRANTED,   16'd0},
    '{1'b0, OP_ALLOC, 32'd1,          16'd0,    1'b1, ST_TOO_LARGE, 16'd0},
    '{1'b1, OP_ALLOC, 32'hFFFF_FFFF,  16'd0,    1'b0, ST_GRANTED,   16'd0},
    '{1'b0, OP_ALLOC, 32'hFFFF_FFFF,  16'd0,    1'b1, ST_USE_PAGES, 16'd0},
    '{1'b0, OP_ALLOC, 32'd512,        16'd0,    1'b0, ST_GRANTED,   16'd0},
    '{1'b1, OP_ALLOC, 32'd512,        16'd0,    1'b0, ST_GRANTED,   16'd0},
    '{1'b0, OP_ALLOC, 32'd512,        16'd0,    1'b0, ST_GRANTED,   16'd0},
    '{1'b0, OP_ALLOC, 32'd513,        16'd0,    1'b1, ST_TOO_LARGE, 16'd0},
    '{1'b0, OP_FREE,  32'd0,          16'd1,    1'b0, ST_GRANTED,   16'd0},
    '{1'b1, OP_ALLOC, 32'd65536,      16'd0,    1'b0, ST_GRANTED,   16'd0}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // req_bytes[31:0], slot_index[47:32]
  logic [0:0]  s_axis_tuser;   // operation[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // granted_slot[15:0]
  logic [2:0]  m_axis_tuser;   // status[2:0]

  logic        busy_map [POOL];
  int unsigned hint_q;
  logic [31:0] limit_q;
  res_t        pending [$];
  logic        calm = 1'b0;
  int          mismatches = 0;
  int          beats_sent = 0;
  int          status_seen [6] = '{default: 0};

  rotating_hint_slot_allocator #(
    .POOL_SLOTS  (POOL),
    .INLINE_BYTES(INLINE)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #6 clk = ~clk;

  function automatic res_t predict_result(input op_t op, input logic [31:0] sz,
                                          input logic [15:0] ix);
    res_t        r;
    int unsigned start, s;
    r.status = ST_POOL_FULL;
    r.slot   = '0;
    if (op == OP_FREE) begin
      if (ix < POOL) begin
        busy_map[ix] = 1'b0;
        r.status = ST_FREED;
      end else begin
        r.status = ST_BAD_INDEX;
      end
    end else if (sz > limit_q) begin
      r.status = ST_TOO_LARGE;
    end else if (sz > INLINE) begin
      r.status = ST_USE_PAGES;
    end else begin
      start  = hint_q;
      hint_q = (hint_q + 1) % POOL;
      for (int i = 0; i < POOL; i++) begin
        s = (start + i) % POOL;
        if (!busy_map[s]) begin
          busy_map[s] = 1'b1;
          r.status = ST_GRANTED;
          r.slot   = s[15:0];
          break;
        end
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_busy();
    int unsigned base, s;
    base = $urandom_range(0, POOL - 1);
    for (int i = 0; i < POOL; i++) begin
      s = (base + i) % POOL;
      if (busy_map[s]) return s[15:0];
    end
    return base[15:0];
  endfunction

  task automatic log_mismatch(input string what, input int want, input int got);
    if (mismatches < 10) $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
    mismatches++;
  endtask

  task automatic send_beat(input op_t op, input logic [31:0] sz, input logic [15:0] ix,
                           input logic typed, input res_t given);
    int   gap;
    res_t want;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ix, sz};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    want = predict_result(op, sz, ix);
    pending.push_back(typed ? given : want);
    beats_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending.size() != 0);
  endtask

  task automatic write_limit(input logic [31:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    limit_q = v;
  endtask

  task automatic random_beat();
    int          pick;
    logic [31:0] sz;
    logic [15:0] ix;
    pick = $urandom_range(0, 99);
    sz   = $urandom();
    ix   = 16'($urandom());
    if (pick < 58) begin
      case ($urandom_range(0, 9))
        0:       sz = limit_q;
        1:       sz = limit_q + 1;
        2:       sz = INLINE;
        3:       sz = INLINE + 1;
        4, 5:    sz = $urandom();
        default: sz = $urandom_range(0, INLINE);
      endcase
      send_beat(OP_ALLOC, sz, ix, 1'b0, '0);
    end else begin
      if (pick < 88) ix = pick_busy();
      else if (pick < 94) ix = 16'($urandom_range(0, POOL - 1));
      else ix = 16'($urandom_range(POOL, 65535));
      send_beat(OP_FREE, sz, ix, 1'b0, '0);
    end
  endtask

  initial begin
    int stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else if (calm || $urandom_range(0, 99) < 72) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (m_axis_tuser < 6) status_seen[m_axis_tuser]++;
      if (pending.size() == 0) begin
        log_mismatch("beat with nothing expected, status", -1, int'(m_axis_tuser));
      end else begin
        want = pending.pop_front();
        if (m_axis_tuser !== want.status)
          log_mismatch("status", int'(want.status), int'(m_axis_tuser));
        if (m_axis_tdata !== want.slot)
          log_mismatch("granted_slot", int'(want.slot), int'(m_axis_tdata));
      end
    end
  end

  initial begin
    #30ms;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [31:0] lim;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    foreach (busy_map[i]) busy_map[i] = 1'b0;
    hint_q  = 0;
    limit_q = DEF_SIZE_LIMIT;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_N; r++) begin
      if (DIR_ROWS[r].is_cfg)
        write_limit(DIR_ROWS[r].value);
      else
        send_beat(DIR_ROWS[r].op, DIR_ROWS[r].value, DIR_ROWS[r].idx, DIR_ROWS[r].typed,
                  '{DIR_ROWS[r].st, DIR_ROWS[r].slot});
    end

    for (int c = 0; c < 6; c++) begin
      case (c)
        0:       lim = DEF_SIZE_LIMIT;
        1:       lim = $urandom();
        2:       lim = 32'd0;
        3:       lim = 32'hFFFF_FFFF;
        4:       lim = INLINE;
        default: lim = $urandom_range(0, 2 * INLINE);
      endcase
      write_limit(lim);
      for (int n = 0; n < 85; n++) begin
        if (n % 45 == 0) calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) == 0) drain();
        random_beat();
      end
    end

    // allocation burst at the default limit, then churn
    calm = 1'b0;
    write_limit(DEF_SIZE_LIMIT);
    repeat (150) send_beat(OP_ALLOC, $urandom_range(0, INLINE), 16'($urandom()), 1'b0, '0);
    repeat (120) random_beat();

    drain();
    repeat (40) @(posedge clk);
    $display("covered %0d beats: directed table, six size_limit settings, burst and churn",
             beats_sent);
    $display("results: %0d granted, %0d too large, %0d page path, %0d full, %0d freed, %0d bad",
             status_seen[ST_GRANTED], status_seen[ST_TOO_LARGE], status_seen[ST_USE_PAGES],
             status_seen[ST_POOL_FULL], status_seen[ST_FREED], status_seen[ST_BAD_INDEX]);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/rhsa_pkg.sv
design/rhsa_busy_mem.sv
design/rhsa_ctrl.sv
design/rotating_hint_slot_allocator.sv
sim/tb_rotating_hint_slot_allocator.sv
